[src/vaccq_pkg.sv]
`timescale 1ns / 1ps

package vaccq_pkg;

	localparam int LANES_DEFAULT = 8;
	localparam int ACTION_W      = 3;
	localparam int LANE_W        = 3;
	localparam int OPERAND_W     = 16;
	localparam int SLICE_W       = 2;
	localparam int ACC_W         = 48;
	localparam int HALF_W        = 32;

	localparam logic [ACTION_W-1:0] ACT_QMUL   = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_QACC   = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_RNDDN  = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_RNDUP  = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_SLICE  = 3'd4;

	localparam logic [SLICE_W-1:0] SEL_HIGH = 2'd0;
	localparam logic [SLICE_W-1:0] SEL_MID  = 2'd1;
	localparam logic [SLICE_W-1:0] SEL_LOW  = 2'd2;
	localparam logic [SLICE_W-1:0] SEL_ZERO = 2'd3;

	localparam logic signed [HALF_W-1:0] SAT_MAX   = 32'sd32767;
	localparam logic signed [HALF_W-1:0] SAT_MIN   = -32'sd32768;
	localparam logic signed [HALF_W-1:0] NEG_BIAS  = 32'sd31;
	localparam logic signed [HALF_W-1:0] ODD_STEP  = 32'sd32;
	localparam int                       ODD_BIT   = 5;
	localparam logic [OPERAND_W-1:0]     QUANT_MASK = 16'hfff0;

	typedef struct packed {
		logic [ACTION_W-1:0]         action;
		logic [LANE_W-1:0]           lane;
		logic signed [OPERAND_W-1:0] first_operand;
		logic signed [OPERAND_W-1:0] second_operand;
		logic                        shift_up;
		logic [SLICE_W-1:0]          slice_select;
	} item_t;

	typedef struct packed {
		logic                 we;
		logic [ACC_W-1:0]     acc;
		logic [OPERAND_W-1:0] res;
	} alu_out_t;

	function automatic logic [OPERAND_W-1:0] sat16(input logic signed [HALF_W-1:0] x);
		if (x > SAT_MAX)
			return SAT_MAX[OPERAND_W-1:0];
		else if (x < SAT_MIN)
			return SAT_MIN[OPERAND_W-1:0];
		else
			return x[OPERAND_W-1:0];
	endfunction

	function automatic logic [OPERAND_W-1:0] quant(input logic signed [HALF_W-1:0] p);
		logic signed [HALF_W-1:0] h;
		h = p >>> 1;
		return sat16(h) & QUANT_MASK;
	endfunction

endpackage

[src/vaccq_acc_file.sv]
`timescale 1ns / 1ps

module vaccq_acc_file #(
	parameter int LANES = vaccq_pkg::LANES_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [vaccq_pkg::LANE_W-1:0]   rd_lane,
	output logic [vaccq_pkg::ACC_W-1:0]    rd_data,
	input  logic                           we,
	input  logic [vaccq_pkg::LANE_W-1:0]   wr_lane,
	input  logic [vaccq_pkg::ACC_W-1:0]    wr_data
);
	import vaccq_pkg::*;

	localparam int IDX_W = (LANES > 1) ? $clog2(LANES) : 1;

	logic [LANES-1:0][ACC_W-1:0] acc_q;
	logic [IDX_W-1:0]            rd_idx;
	logic [IDX_W-1:0]            wr_idx;
	logic                        rd_ok;
	logic                        wr_ok;

	assign rd_idx = IDX_W'(rd_lane);
	assign wr_idx = IDX_W'(wr_lane);
	assign rd_ok  = 32'(rd_lane) < LANES;
	assign wr_ok  = 32'(wr_lane) < LANES;

	assign rd_data = rd_ok ? acc_q[rd_idx] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (we && wr_ok) begin
			acc_q[wr_idx] <= wr_data;
		end
	end

endmodule

[src/vaccq_lane_alu.sv]
`timescale 1ns / 1ps

module vaccq_lane_alu (
	input  vaccq_pkg::item_t             item,
	input  logic                         lane_ok,
	input  logic [vaccq_pkg::ACC_W-1:0]  acc,
	output vaccq_pkg::alu_out_t          alu
);
	import vaccq_pkg::*;

	logic signed [HALF_W-1:0] a32;
	logic signed [HALF_W-1:0] b32;
	logic signed [HALF_W-1:0] prod;
	logic signed [HALF_W-1:0] pm;
	logic signed [HALF_W-1:0] pa;
	logic [ACC_W-1:0]         addend;
	logic [ACC_W-1:0]         sum;
	logic                     do_add;
	logic [ACC_W-1:0]         rnd;

	always_comb begin
		a32  = HALF_W'($signed(item.first_operand));
		b32  = HALF_W'($signed(item.second_operand));
		prod = a32 * b32;
		pm   = prod[HALF_W-1] ? prod + NEG_BIAS : prod;

		pa = $signed(acc[ACC_W-1:OPERAND_W]);
		if (!pa[ODD_BIT]) begin
			if (pa[HALF_W-1])
				pa = pa + ODD_STEP;
			else if (pa >= ODD_STEP)
				pa = pa - ODD_STEP;
		end

		addend = ACC_W'($signed(item.second_operand));
		if (item.shift_up)
			addend = {addend[ACC_W-OPERAND_W-1:0], {OPERAND_W{1'b0}}};
		sum    = acc + addend;
		do_add = (item.action == ACT_RNDUP) != acc[ACC_W-1];
		rnd    = do_add ? sum : acc;
	end

	always_comb begin
		alu.we  = 1'b0;
		alu.acc = acc;
		alu.res = '0;
		if (lane_ok) begin
			unique case (item.action)
				ACT_QMUL: begin
					alu.we  = 1'b1;
					alu.acc = {pm, {OPERAND_W{1'b0}}};
					alu.res = quant(pm);
				end
				ACT_QACC: begin
					alu.we  = 1'b1;
					alu.acc = {pa, acc[OPERAND_W-1:0]};
					alu.res = quant(pa);
				end
				ACT_RNDDN, ACT_RNDUP: begin
					alu.we  = 1'b1;
					alu.acc = rnd;
					alu.res = sat16($signed(rnd[ACC_W-1:OPERAND_W]));
				end
				ACT_SLICE: begin
					unique case (item.slice_select)
						SEL_HIGH: alu.res = acc[ACC_W-1:HALF_W];
						SEL_MID:  alu.res = acc[HALF_W-1:OPERAND_W];
						SEL_LOW:  alu.res = acc[OPERAND_W-1:0];
						SEL_ZERO: alu.res = '0;
						default:  alu.res = '0;
					endcase
				end
				default: begin
					alu.res = '0;
				end
			endcase
		end
	end

endmodule

[src/vector_accumulator_round_quantize_core.sv]
`timescale 1ns / 1ps
// Per-lane 48-bit accumulator unit: quantized multiply, quantized
// accumulate, round down/up and accumulator slice read.
// Input channel: in_valid/in_ready carry one word (action, lane, operands,
// shift_up, slice_select). Output channel: out_valid/out_ready carry the
// 16-bit result and its lane.
// A word is caught in an input register; the next edge with the result
// register free or being taken runs the multiply or add against the
// lane's accumulator, writes the accumulator back and loads the result
// register. Throughput is one word per cycle while out_ready holds. The
// accumulator write and the read for the following word sit on either
// side of the same edge, so dependent words on one lane follow back to back.
// When the receiver stalls, the result register holds, the input register
// fills, and in_ready then drops until out_ready returns.
// Reset clears all accumulators to zero and both valid flags at once;
// no clearing pass.
// Lanes at or beyond LANES and unused action codes give a zero result
// and leave all accumulators unchanged.
module vector_accumulator_round_quantize_core #(
	parameter int LANES = vaccq_pkg::LANES_DEFAULT
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [vaccq_pkg::ACTION_W-1:0]        action,
	input  logic [vaccq_pkg::LANE_W-1:0]          lane,
	input  logic signed [vaccq_pkg::OPERAND_W-1:0] first_operand,
	input  logic signed [vaccq_pkg::OPERAND_W-1:0] second_operand,
	input  logic                                  shift_up,
	input  logic [vaccq_pkg::SLICE_W-1:0]         slice_select,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [vaccq_pkg::OPERAND_W-1:0] result,
	output logic [vaccq_pkg::LANE_W-1:0]          result_lane
);
	import vaccq_pkg::*;

	item_t                item_s1;
	logic                 valid_s1;
	logic                 adv_s1;
	logic                 lane_ok;
	logic [ACC_W-1:0]     acc_rd;
	alu_out_t             alu;
	logic                 acc_we;
	logic [OPERAND_W-1:0] result_s2;
	logic [LANE_W-1:0]    lane_s2;
	logic                 valid_s2;

	assign adv_s1   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s1;
	assign lane_ok  = 32'(item_s1.lane) < LANES;
	assign acc_we   = adv_s1 && alu.we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.action         <= action;
			item_s1.lane           <= lane;
			item_s1.first_operand  <= first_operand;
			item_s1.second_operand <= second_operand;
			item_s1.shift_up       <= shift_up;
			item_s1.slice_select   <= slice_select;
		end
	end

	vaccq_acc_file #(
		.LANES(LANES)
	) u_acc_file (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_lane (item_s1.lane),
		.rd_data (acc_rd),
		.we      (acc_we),
		.wr_lane (item_s1.lane),
		.wr_data (alu.acc)
	);

	vaccq_lane_alu u_lane_alu (
		.item    (item_s1),
		.lane_ok (lane_ok),
		.acc     (acc_rd),
		.alu     (alu)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_s2 <= alu.res;
			lane_s2   <= item_s1.lane;
		end
	end

	assign out_valid   = valid_s2;
	assign result      = $signed(result_s2);
	assign result_lane = lane_s2;

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=> (valid_s1 && $stable(item_s1)))
		else $error("input register lost a stalled word");

	a_lane_follow: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> (valid_s2 && result_lane == $past(item_s1.lane)))
		else $error("result lane does not follow the advancing word");

	a_slice_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && (item_s1.action == ACT_SLICE || !lane_ok)) |-> !acc_we)
		else $error("accumulator written by a read-only word");

endmodule

[dv/vaccq_lane_checker.sv]
`timescale 1ns / 1ps

module vaccq_lane_checker #(
	parameter int LANES = vaccq_pkg::LANES_DEFAULT
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	input  logic                                   in_ready,
	input  logic [vaccq_pkg::ACTION_W-1:0]         action,
	input  logic [vaccq_pkg::LANE_W-1:0]           lane,
	input  logic signed [vaccq_pkg::OPERAND_W-1:0] first_operand,
	input  logic signed [vaccq_pkg::OPERAND_W-1:0] second_operand,
	input  logic                                   shift_up,
	input  logic [vaccq_pkg::SLICE_W-1:0]          slice_select,
	input  logic                                   out_valid,
	input  logic                                   out_ready,
	input  logic signed [vaccq_pkg::OPERAND_W-1:0] result,
	input  logic [vaccq_pkg::LANE_W-1:0]           result_lane,
	output int                                     errors,
	output int                                     outstanding,
	output int                                     checked
);

	import vaccq_pkg::*;

	typedef struct packed {
		logic [OPERAND_W-1:0] value;
		logic [LANE_W-1:0]    lane;
	} lane_result_t;

	logic [ACC_W-1:0] acc_bank [LANES];
	lane_result_t     lane_results_q [$];
	int               n_err;
	int               n_chk;

	function automatic logic [OPERAND_W-1:0] saturate16(input longint x);
		if (x > longint'(SAT_MAX))
			return SAT_MAX[OPERAND_W-1:0];
		if (x < longint'(SAT_MIN))
			return SAT_MIN[OPERAND_W-1:0];
		return x[OPERAND_W-1:0];
	endfunction

	function automatic logic [OPERAND_W-1:0] quantise(input longint p);
		return saturate16(p >>> 1) & QUANT_MASK;
	endfunction

	// updates the lane accumulator where the action writes it and returns the word the block should answer with
	function automatic lane_result_t lane_outcome(
		input logic [ACTION_W-1:0]         act,
		input logic [LANE_W-1:0]           ln,
		input logic signed [OPERAND_W-1:0] a,
		input logic signed [OPERAND_W-1:0] b,
		input logic                        shift,
		input logic [SLICE_W-1:0]          sel
	);
		longint           p;
		longint           addend;
		logic [ACC_W-1:0] acc;
		lane_result_t     r;
		r.lane  = ln;
		r.value = '0;
		if (int'(ln) >= LANES)
			return r;
		acc = acc_bank[ln];
		case (act)
			ACT_QMUL: begin
				p = longint'(a) * longint'(b);
				if (p < 0)
					p += longint'(NEG_BIAS);
				acc_bank[ln] = {p[HALF_W-1:0], 16'h0000};
				r.value = quantise(p);
			end
			ACT_QACC: begin
				p = longint'($signed(acc[ACC_W-1:16]));
				if (p[ODD_BIT] == 1'b0) begin
					if (p < 0)
						p += longint'(ODD_STEP);
					else if (p >= longint'(ODD_STEP))
						p -= longint'(ODD_STEP);
				end
				acc_bank[ln] = {p[HALF_W-1:0], acc[15:0]};
				r.value = quantise(p);
			end
			ACT_RNDDN, ACT_RNDUP: begin
				// add only when the accumulator sign disagrees with the mode
				if ((act == ACT_RNDUP) != acc[ACC_W-1]) begin
					addend = shift ? (longint'(b) <<< 16) : longint'(b);
					acc = acc + addend[ACC_W-1:0];
				end
				acc_bank[ln] = acc;
				r.value = saturate16(longint'($signed(acc[ACC_W-1:16])));
			end
			ACT_SLICE: begin
				case (sel)
					SEL_HIGH: r.value = acc[47:32];
					SEL_MID:  r.value = acc[31:16];
					SEL_LOW:  r.value = acc[15:0];
					default:  r.value = '0;
				endcase
			end
			default: r.value = '0;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lane_result_t exp_word;
		if (!arst_n) begin
			for (int i = 0; i < LANES; i++)
				acc_bank[i] = '0;
			lane_results_q.delete();
			n_err = 0;
			n_chk = 0;
			errors      <= 0;
			outstanding <= 0;
			checked     <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (lane_results_q.size() == 0) begin
					$display("%0t unexpected word: result %h lane %0d", $time, result,
						result_lane);
					n_err++;
				end else begin
					exp_word = lane_results_q.pop_front();
					n_chk++;
					if (result !== exp_word.value) begin
						$display("%0t result mismatch: expected %h actual %h (lane %0d)",
							$time, exp_word.value, result, exp_word.lane);
						n_err++;
					end
					if (result_lane !== exp_word.lane) begin
						$display("%0t result_lane mismatch: expected %0d actual %0d",
							$time, exp_word.lane, result_lane);
						n_err++;
					end
				end
			end
			if (in_valid && in_ready)
				lane_results_q.push_back(lane_outcome(action, lane, first_operand,
					second_operand, shift_up, slice_select));
			errors      <= n_err;
			outstanding <= lane_results_q.size();
			checked     <= n_chk;
		end
	end

endmodule

[dv/tb_vector_accumulator_round_quantize_core.sv]
`timescale 1ns / 1ps

module tb_vector_accumulator_round_quantize_core;

	import vaccq_pkg::*;

	localparam int RANDOM_WORDS = 530;

	logic                        clk;
	logic                        arst_n         = 1'b0;
	logic                        in_valid       = 1'b0;
	logic                        in_ready;
	logic [ACTION_W-1:0]         action         = ACT_SLICE;
	logic [LANE_W-1:0]           lane           = '0;
	logic signed [OPERAND_W-1:0] first_operand  = '0;
	logic signed [OPERAND_W-1:0] second_operand = '0;
	logic                        shift_up       = 1'b0;
	logic [SLICE_W-1:0]          slice_select   = SEL_HIGH;
	logic                        out_valid;
	logic                        out_ready      = 1'b0;
	logic signed [OPERAND_W-1:0] result;
	logic [LANE_W-1:0]           result_lane;

	bit steady = 1'b0;
	int errors;
	int outstanding;
	int checked;
	int words_per_action [8];

	vector_accumulator_round_quantize_core dut (
		.clk, .arst_n, .in_valid, .in_ready, .action, .lane, .first_operand,
		.second_operand, .shift_up, .slice_select, .out_valid, .out_ready,
		.result, .result_lane
	);

	vaccq_lane_checker chk (
		.clk, .arst_n, .in_valid, .in_ready, .action, .lane, .first_operand,
		.second_operand, .shift_up, .slice_select, .out_valid, .out_ready,
		.result, .result_lane, .errors, .outstanding, .checked
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("%0t timeout: %0d results still awaited", $time, outstanding);
		$display("== FAIL ==");
		$finish;
	end

	// receiver back-pressure
	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= steady || ($urandom_range(0, 99) >= 25);
	end

	function automatic item_t make_word(input logic [ACTION_W-1:0] act,
		input logic [LANE_W-1:0] ln, input int a, input int b,
		input logic shift, input logic [SLICE_W-1:0] sel);
		item_t w;
		w.action         = act;
		w.lane           = ln;
		w.first_operand  = a[OPERAND_W-1:0];
		w.second_operand = b[OPERAND_W-1:0];
		w.shift_up       = shift;
		w.slice_select   = sel;
		return w;
	endfunction

	function automatic logic [OPERAND_W-1:0] pick_operand();
		case ($urandom_range(0, 11))
			0:       return 16'h7fff;
			1:       return 16'h8000;
			2:       return 16'h0000;
			3:       return 16'hffff;
			4:       return OPERAND_W'($urandom_range(0, 63));
			default: return OPERAND_W'($urandom);
		endcase
	endfunction

	function automatic item_t random_word();
		item_t w;
		int    pick;
		pick = $urandom_range(0, 99);
		if (pick < 20)
			w.action = ACT_QMUL;
		else if (pick < 38)
			w.action = ACT_QACC;
		else if (pick < 56)
			w.action = ACT_RNDDN;
		else if (pick < 74)
			w.action = ACT_RNDUP;
		else if (pick < 96)
			w.action = ACT_SLICE;
		else
			w.action = ACTION_W'($urandom_range(5, 7));
		w.lane           = LANE_W'($urandom_range(0, 7));
		w.first_operand  = pick_operand();
		w.second_operand = pick_operand();
		w.shift_up       = 1'($urandom_range(0, 1));
		w.slice_select   = SLICE_W'($urandom_range(0, 3));
		return w;
	endfunction

	task automatic send_word(input item_t w);
		int gap;
		gap = 0;
		if (!steady)
			while ($urandom_range(0, 99) < 25)
				gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		action         <= w.action;
		lane           <= w.lane;
		first_operand  <= w.first_operand;
		second_operand <= w.second_operand;
		shift_up       <= w.shift_up;
		slice_select   <= w.slice_select;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		words_per_action[w.action]++;
	endtask

	initial begin
		item_t directed [$];
		int    n_words;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full-scale product, then every slice of it
		directed.push_back(make_word(ACT_QMUL,  3'd0, -32768, -32768, 1'b0, SEL_HIGH));
		directed.push_back(make_word(ACT_SLICE, 3'd0, 0, 0, 1'b0, SEL_HIGH));
		directed.push_back(make_word(ACT_SLICE, 3'd0, 0, 0, 1'b1, SEL_MID));
		directed.push_back(make_word(ACT_SLICE, 3'd0, 0, 0, 1'b0, SEL_LOW));
		directed.push_back(make_word(ACT_SLICE, 3'd0, 0, 0, 1'b0, SEL_ZERO));
		directed.push_back(make_word(ACT_QACC,  3'd0, 0, 0, 1'b0, SEL_HIGH));
		// negative product takes the bias
		directed.push_back(make_word(ACT_QMUL,  3'd1, 32767, -32768, 1'b0, SEL_HIGH));
		directed.push_back(make_word(ACT_QACC,  3'd1, 0, 0, 1'b0, SEL_HIGH));
		directed.push_back(make_word(ACT_RNDDN, 3'd1, 0, -32768, 1'b1, SEL_HIGH));
		directed.push_back(make_word(ACT_RNDUP, 3'd1, 0, 32767, 1'b0, SEL_HIGH));
		// small values: bit 5 clear inside the dead band, bit 5 set
		directed.push_back(make_word(ACT_QMUL,  3'd2, 1, -1, 1'b0, SEL_HIGH));
		directed.push_back(make_word(ACT_QACC,  3'd2, 0, 0, 1'b0, SEL_HIGH));
		directed.push_back(make_word(ACT_QMUL,  3'd3, 3, 11, 1'b0, SEL_HIGH));
		directed.push_back(make_word(ACT_QACC,  3'd3, 0, 0, 1'b0, SEL_HIGH));
		// rounding on a zero then a negative accumulator
		directed.push_back(make_word(ACT_RNDUP, 3'd4, 0, -1, 1'b0, SEL_HIGH));
		directed.push_back(make_word(ACT_RNDDN, 3'd4, 0, 32767, 1'b1, SEL_HIGH));
		directed.push_back(make_word(ACT_SLICE, 3'd4, 0, 0, 1'b0, SEL_LOW));
		directed.push_back(make_word(ACT_QMUL,  3'd7, 0, 0, 1'b0, SEL_HIGH));
		directed.push_back(make_word(ACT_QACC,  3'd7, 0, 0, 1'b0, SEL_HIGH));
		// unused codes leave the lane alone
		directed.push_back(make_word(3'd5, 3'd5, -1, -1, 1'b1, SEL_ZERO));
		directed.push_back(make_word(3'd6, 3'd5, 32767, -32768, 1'b0, SEL_MID));
		directed.push_back(make_word(3'd7, 3'd5, -32768, 32767, 1'b1, SEL_LOW));
		directed.push_back(make_word(ACT_RNDUP, 3'd5, 0, 32767, 1'b1, SEL_HIGH));
		directed.push_back(make_word(ACT_SLICE, 3'd5, 0, 0, 1'b0, SEL_HIGH));
		directed.push_back(make_word(ACT_RNDDN, 3'd6, 0, -32768, 1'b1, SEL_HIGH));

		foreach (directed[i])
			send_word(directed[i]);

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i == 200)
				steady <= 1'b1;
			else if (i == 330)
				steady <= 1'b0;
			send_word(random_word());
		end
		in_valid <= 1'b0;

		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (8) @(posedge clk);

		n_words = 0;
		foreach (words_per_action[i])
			n_words += words_per_action[i];
		$display("Sent %0d words: qmul %0d, qacc %0d, round down %0d, round up %0d, slice %0d",
			n_words, words_per_action[ACT_QMUL], words_per_action[ACT_QACC],
			words_per_action[ACT_RNDDN], words_per_action[ACT_RNDUP],
			words_per_action[ACT_SLICE]);
		$display("Unused codes %0d; %0d results compared, %0d mismatches",
			words_per_action[5] + words_per_action[6] + words_per_action[7], checked, errors);
		if (errors == 0 && outstanding == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
